// ===== design/lpr_pkg.sv =====
// shared types and constants of the line pixel rasterizer
package lpr_pkg;

  // field widths
  localparam int unsigned COORD_W   = 6;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned CLIP_W    = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = COLOR_W;
  localparam int unsigned ERR_W     = COORD_W + 1;

  // default tile edge
  localparam int unsigned TILE_SIZE_DEF = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_HEIGHT = 2'd2;

  // register reset values
  localparam logic [COLOR_W-1:0] DRAW_COLOR_RST  = 24'hFF_FFFF;
  localparam logic [CLIP_W-1:0]  CLIP_WIDTH_RST  = 7'd64;
  localparam logic [CLIP_W-1:0]  CLIP_HEIGHT_RST = 7'd64;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } lpr_state_e;

endpackage

// ===== design/line_pixel_rasterizer.sv =====
// line rasterizer top level: setup, error-accumulator stepping and output register
//
// One line segment word is taken when idle; the next cycle sorts out the major
// axis, step directions and deltas, and from then on the single error
// accumulator adder steps one pixel per cycle into the output register,
// stalling while that register is full and not taken. Coordinates above
// TILE_SIZE - 1 are saturated. Horizontal and vertical lines walk upward
// from the smaller coordinate and leave out the larger one; other lines skip
// the start pixel and include the end pixel. The user must write
// configuration only while idle; the block itself does not enforce it.
module line_pixel_rasterizer #(
  parameter int unsigned TILE_SIZE = lpr_pkg::TILE_SIZE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [lpr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lpr_pkg::CFG_W-1:0]       cfg_data_i,
  // segment input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lpr_pkg::COORD_W-1:0]     start_x_i,
  input  logic [lpr_pkg::COORD_W-1:0]     start_y_i,
  input  logic [lpr_pkg::COORD_W-1:0]     end_x_i,
  input  logic [lpr_pkg::COORD_W-1:0]     end_y_i,
  // pixel output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lpr_pkg::COORD_W-1:0]     pixel_x_o,
  output logic [lpr_pkg::COORD_W-1:0]     pixel_y_o,
  output logic                            inside_res_o,
  output logic [lpr_pkg::COLOR_W-1:0]     color_o,
  output logic                            last_o
);
  import lpr_pkg::*;

  localparam logic [COORD_W-1:0] TILE_MAX = COORD_W'(TILE_SIZE - 1);
  localparam logic [COORD_W-1:0] ONE      = COORD_W'(1);

  // configuration registers
  logic [COLOR_W-1:0] draw_color_q;
  logic [CLIP_W-1:0]  clip_width_q, clip_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_color_q  <= DRAW_COLOR_RST;
      clip_width_q  <= CLIP_WIDTH_RST;
      clip_height_q <= CLIP_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DRAW_COLOR:  draw_color_q  <= cfg_data_i[COLOR_W-1:0];
        REG_CLIP_WIDTH:  clip_width_q  <= cfg_data_i[CLIP_W-1:0];
        REG_CLIP_HEIGHT: clip_height_q <= cfg_data_i[CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  lpr_state_e         state_q, state_d;
  logic [COORD_W-1:0] x0_q, y0_q, x1_q, y1_q;
  logic [COORD_W-1:0] px_q, px_d, py_q, py_d;
  logic [COORD_W-1:0] amax_q, amax_d, amin_q, amin_d, cnt_q, cnt_d;
  logic [ERR_W-1:0]   err_q, err_d;
  logic               sx_q, sx_d, sy_q, sy_d, xmaj_q, xmaj_d;

  // output register
  logic               ovalid_q, ovalid_d, olast_q, olast_d, oinside_q, oinside_d;
  logic [COORD_W-1:0] ox_q, ox_d, oy_q, oy_d;
  logic [COLOR_W-1:0] ocolor_q, ocolor_d;

  logic in_fire, out_free;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !ovalid_q || out_ready_i;

  // saturate coordinates to the tile and hold them for setup
  function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
    sat_coord = (v > TILE_MAX) ? TILE_MAX : v;
  endfunction

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x0_q <= sat_coord(start_x_i);
      y0_q <= sat_coord(start_y_i);
      x1_q <= sat_coord(end_x_i);
      y1_q <= sat_coord(end_y_i);
    end
  end

  // setup values: deltas, directions, major axis
  logic               xgt, ygt;
  logic [COORD_W-1:0] ax, ay;
  assign xgt = x1_q > x0_q;
  assign ygt = y1_q > y0_q;
  assign ax  = xgt ? (x1_q - x0_q) : (x0_q - x1_q);
  assign ay  = ygt ? (y1_q - y0_q) : (y0_q - y1_q);

  // shared step unit: accumulate minor delta, compare and fold against major
  logic [ERR_W-1:0]   err_sum;
  logic               minor_step;
  logic [COORD_W-1:0] px_step, py_step;
  assign err_sum    = err_q + ERR_W'(amin_q);
  assign minor_step = err_sum >= ERR_W'(amax_q);
  assign px_step    = sx_q ? (px_q + ONE) : (px_q - ONE);
  assign py_step    = sy_q ? (py_q + ONE) : (py_q - ONE);

  // next state and datapath control
  always_comb begin
    state_d   = state_q;
    px_d      = px_q;
    py_d      = py_q;
    amax_d    = amax_q;
    amin_d    = amin_q;
    cnt_d     = cnt_q;
    err_d     = err_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    xmaj_d    = xmaj_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    ox_d      = ox_q;
    oy_d      = oy_q;
    oinside_d = oinside_q;
    ocolor_d  = ocolor_q;
    olast_d   = olast_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        if (x0_q == x1_q) begin
          // vertical: walk up from one below the smaller y, no minor motion
          xmaj_d = 1'b0;
          px_d   = x0_q;
          py_d   = (ygt ? y0_q : y1_q) - ONE;
          sx_d   = 1'b1;
          sy_d   = 1'b1;
          amax_d = ay;
          amin_d = '0;
        end else if (y0_q == y1_q) begin
          // horizontal: walk right from one left of the smaller x
          xmaj_d = 1'b1;
          px_d   = (xgt ? x0_q : x1_q) - ONE;
          py_d   = y0_q;
          sx_d   = 1'b1;
          sy_d   = 1'b1;
          amax_d = ax;
          amin_d = '0;
        end else begin
          xmaj_d = ax >= ay;
          px_d   = x0_q;
          py_d   = y0_q;
          sx_d   = xgt;
          sy_d   = ygt;
          amax_d = (ax >= ay) ? ax : ay;
          amin_d = (ax >= ay) ? ay : ax;
        end
        err_d   = ERR_W'(amax_d >> 1);
        cnt_d   = amax_d;
        state_d = (amax_d == '0) ? ST_IDLE : ST_RUN;
      end
      ST_RUN: begin
        if (out_free) begin
          err_d = minor_step ? (err_sum - ERR_W'(amax_q)) : err_sum;
          if (xmaj_q) begin
            px_d = px_step;
            if (minor_step) py_d = py_step;
          end else begin
            py_d = py_step;
            if (minor_step) px_d = px_step;
          end
          cnt_d     = cnt_q - ONE;
          ovalid_d  = 1'b1;
          ox_d      = px_d;
          oy_d      = py_d;
          oinside_d = (CLIP_W'(px_d) < clip_width_q) && (CLIP_W'(py_d) < clip_height_q);
          ocolor_d  = draw_color_q;
          olast_d   = (cnt_q == ONE);
          if (cnt_q == ONE) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      cnt_q    <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    px_q      <= px_d;
    py_q      <= py_d;
    amax_q    <= amax_d;
    amin_q    <= amin_d;
    err_q     <= err_d;
    sx_q      <= sx_d;
    sy_q      <= sy_d;
    xmaj_q    <= xmaj_d;
    ox_q      <= ox_d;
    oy_q      <= oy_d;
    oinside_q <= oinside_d;
    ocolor_q  <= ocolor_d;
    olast_q   <= olast_d;
  end

  assign out_valid_o  = ovalid_q;
  assign pixel_x_o    = ox_q;
  assign pixel_y_o    = oy_q;
  assign inside_res_o = oinside_q;
  assign color_o      = ocolor_q;
  assign last_o       = olast_q;

  // stepping always has pixels left to emit
  a_run_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q != '0))
    else $error("run state with no pixels left");

  // error accumulator stays below the major delta while stepping
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (err_q < ERR_W'(amax_q)))
    else $error("error accumulator out of range");

  // the final step loads a pixel marked last and returns to idle
  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && out_free && cnt_q == ONE) |=>
      (out_valid_o && last_o && state_q == ST_IDLE))
    else $error("final pixel not marked last");

endmodule

// ===== dv/lpr_pixel_checker.sv =====
// pixel stream checker for the line rasterizer: predicts each segment's pixels and compares
module lpr_pixel_checker #(
  parameter int unsigned TILE_SIZE = lpr_pkg::TILE_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lpr_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [lpr_pkg::COORD_W-1:0]   start_x_i,
  input  logic [lpr_pkg::COORD_W-1:0]   start_y_i,
  input  logic [lpr_pkg::COORD_W-1:0]   end_x_i,
  input  logic [lpr_pkg::COORD_W-1:0]   end_y_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [lpr_pkg::COORD_W-1:0]   pixel_x_i,
  input  logic [lpr_pkg::COORD_W-1:0]   pixel_y_i,
  input  logic                          inside_res_i,
  input  logic [lpr_pkg::COLOR_W-1:0]   color_i,
  input  logic                          last_i,
  output int                            mismatch_cnt_o,
  output int                            pending_o
);
  import lpr_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               in_map;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  // local copy of the register file
  logic [COLOR_W-1:0] draw_color;
  logic [CLIP_W-1:0]  clip_w;
  logic [CLIP_W-1:0]  clip_h;

  pixel_t expected_pixels[$];

  // coordinates past the tile edge clamp to the last column or row
  function automatic int clamp_to_tile(logic [COORD_W-1:0] v);
    return (int'(v) > int'(TILE_SIZE) - 1) ? int'(TILE_SIZE) - 1 : int'(v);
  endfunction

  function automatic void queue_pixel(int x, int y, bit is_last);
    pixel_t p;
    p.x      = x[COORD_W-1:0];
    p.y      = y[COORD_W-1:0];
    p.in_map = ({1'b0, p.x} < clip_w) && ({1'b0, p.y} < clip_h);
    p.color  = draw_color;
    p.last   = is_last;
    expected_pixels.push_back(p);
  endfunction

  // walk one segment in drawing order
  function automatic void rasterize_segment(int x0, int y0, int x1, int y1);
    int lo, hi, dx, dy, ax, ay, sx, sy, px, py, err;
    if (x0 == x1) begin
      // vertical: upward from the smaller y, larger one left out
      lo = (y0 < y1) ? y0 : y1;
      hi = (y0 < y1) ? y1 : y0;
      for (int i = lo; i < hi; i++) queue_pixel(x0, i, i == hi - 1);
    end else if (y0 == y1) begin
      lo = (x0 < x1) ? x0 : x1;
      hi = (x0 < x1) ? x1 : x0;
      for (int i = lo; i < hi; i++) queue_pixel(i, y0, i == hi - 1);
    end else begin
      // general case: error accumulator along the major axis, start pixel skipped
      dx = x1 - x0;
      dy = y1 - y0;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      sx = (dx > 0) ? 1 : -1;
      sy = (dy > 0) ? 1 : -1;
      px = x0;
      py = y0;
      if (ax >= ay) begin
        err = ax / 2;
        for (int i = 0; i < ax; i++) begin
          err += ay;
          if (err >= ax) begin
            err -= ax;
            py += sy;
          end
          px += sx;
          queue_pixel(px, py, i == ax - 1);
        end
      end else begin
        err = ay / 2;
        for (int i = 0; i < ay; i++) begin
          err += ax;
          if (err >= ay) begin
            err -= ay;
            px += sx;
          end
          py += sy;
          queue_pixel(px, py, i == ay - 1);
        end
      end
    end
  endfunction

  // register writes, segment prediction and pixel comparison
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got;
    pixel_t exp_px;
    if (!rst_ni) begin
      draw_color = DRAW_COLOR_RST;
      clip_w     = CLIP_WIDTH_RST;
      clip_h     = CLIP_HEIGHT_RST;
      expected_pixels.delete();
      mismatch_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DRAW_COLOR:  draw_color = cfg_data_i[COLOR_W-1:0];
          REG_CLIP_WIDTH:  clip_w     = cfg_data_i[CLIP_W-1:0];
          REG_CLIP_HEIGHT: clip_h     = cfg_data_i[CLIP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        rasterize_segment(clamp_to_tile(start_x_i), clamp_to_tile(start_y_i),
                          clamp_to_tile(end_x_i), clamp_to_tile(end_y_i));
      end
      if (out_valid_i && out_ready_i) begin
        got = '{pixel_x_i, pixel_y_i, inside_res_i, color_i, last_i};
        if (expected_pixels.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= 10)
            $display("unexpected pixel word: x=%0d y=%0d inside=%0b color=%06h last=%0b",
                     got.x, got.y, got.in_map, got.color, got.last);
        end else begin
          exp_px = expected_pixels.pop_front();
          if (got !== exp_px) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= 10) begin
              $display("pixel mismatch, expected: x=%0d y=%0d inside=%0b color=%06h last=%0b",
                       exp_px.x, exp_px.y, exp_px.in_map, exp_px.color, exp_px.last);
              $display("                  actual: x=%0d y=%0d inside=%0b color=%06h last=%0b",
                       got.x, got.y, got.in_map, got.color, got.last);
            end
          end
        end
      end
    end
    pending_o = expected_pixels.size();
  end

endmodule

// ===== dv/testbench.sv =====
// testbench top for the line rasterizer: clock, reset, segment and register stimulus, verdict
module testbench;
  import lpr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 150;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 70;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = REG_DRAW_COLOR;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [COORD_W-1:0]   start_x  = '0;
  logic [COORD_W-1:0]   start_y  = '0;
  logic [COORD_W-1:0]   end_x    = '0;
  logic [COORD_W-1:0]   end_y    = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COORD_W-1:0]   pixel_x;
  logic [COORD_W-1:0]   pixel_y;
  logic                 inside_res;
  logic [COLOR_W-1:0]   color;
  logic                 last;

  int mismatch_cnt;
  int pending_cnt;
  int idle_cycles   = 0;
  int segments_sent = 0;
  int pixels_seen   = 0;
  int stall_left    = 0;
  bit hold_request  = 1'b0;
  bit calm_tail     = 1'b0;

  wire in_fire  = in_valid && in_ready;
  wire out_fire = out_valid && out_ready;

  line_pixel_rasterizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .start_x_i   (start_x),
    .start_y_i   (start_y),
    .end_x_i     (end_x),
    .end_y_i     (end_y),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .pixel_x_o   (pixel_x),
    .pixel_y_o   (pixel_y),
    .inside_res_o(inside_res),
    .color_o     (color),
    .last_o      (last)
  );

  lpr_pixel_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .start_x_i     (start_x),
    .start_y_i     (start_y),
    .end_x_i       (end_x),
    .end_y_i       (end_y),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_x_i     (pixel_x),
    .pixel_y_i     (pixel_y),
    .inside_res_i  (inside_res),
    .color_i       (color),
    .last_i        (last),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending_cnt)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // pixel receiver: short random stalls, plus one long hold on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end else if (stall_left == 0 && !calm_tail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog and traffic counters
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) segments_sent++;
      if (out_fire) pixels_seen++;
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [COORD_W-1:0] clamp_coord(int v);
    return (v < 0) ? '0 : (v > 63) ? COORD_W'(63) : COORD_W'(v);
  endfunction

  // offer one segment word and hold it until taken
  task automatic send_segment(input logic [COORD_W-1:0] x0, y0, x1, y1);
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    start_x  <= x0;
    start_y  <= y0;
    end_x    <= x1;
    end_y    <= y1;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // mix of zero-length, axis-aligned, short and arbitrary segments
  task automatic send_random_segment();
    int kind;
    logic [COORD_W-1:0] x0, y0, x1, y1;
    kind = $urandom_range(0, 15);
    x0 = COORD_W'($urandom_range(0, 63));
    y0 = COORD_W'($urandom_range(0, 63));
    x1 = COORD_W'($urandom_range(0, 63));
    y1 = COORD_W'($urandom_range(0, 63));
    case (kind)
      0: begin
        x1 = x0;
        y1 = y0;
      end
      1, 2: x1 = x0;
      3, 4: y1 = y0;
      5, 6, 7: begin
        x1 = clamp_coord(int'(x0) + int'($urandom_range(0, 8)) - 4);
        y1 = clamp_coord(int'(y0) + int'($urandom_range(0, 8)) - 4);
      end
      default: ;
    endcase
    send_segment(x0, y0, x1, y1);
  endtask

  // stop offering and wait for every expected pixel plus a short settle
  task automatic wait_idle(int settle);
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] draw_color, clip_w, clip_h);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_DRAW_COLOR;
    cfg_data <= draw_color;
    @(posedge clk_i);
    cfg_idx  <= REG_CLIP_WIDTH;
    cfg_data <= clip_w;
    @(posedge clk_i);
    cfg_idx  <= REG_CLIP_HEIGHT;
    cfg_data <= clip_h;
    @(posedge clk_i);
    // write to an unmapped index must change nothing
    cfg_idx  <= REG_UNUSED;
    cfg_data <= CFG_W'($urandom);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic run_phase(int n_items, logic [CFG_W-1:0] draw_color, clip_w, clip_h,
                           bit long_hold);
    wait_idle(SETTLE_CYCLES);
    program_regs(draw_color, clip_w, clip_h);
    for (int i = 0; i < n_items; i++) begin
      if (long_hold && i == 5) hold_request = 1'b1;
      send_random_segment();
    end
  endtask

  // directed segments: zero length, both axes both ways, diagonals, steep and shallow
  localparam int N_DIRECTED = 20;
  localparam logic [4*COORD_W-1:0] DIRECTED [N_DIRECTED] = '{
    {6'd0,  6'd0,  6'd0,  6'd0},
    {6'd63, 6'd63, 6'd63, 6'd63},
    {6'd5,  6'd0,  6'd5,  6'd63},
    {6'd5,  6'd63, 6'd5,  6'd0},
    {6'd0,  6'd7,  6'd63, 6'd7},
    {6'd63, 6'd7,  6'd0,  6'd7},
    {6'd0,  6'd0,  6'd63, 6'd63},
    {6'd63, 6'd63, 6'd0,  6'd0},
    {6'd0,  6'd63, 6'd63, 6'd0},
    {6'd63, 6'd0,  6'd0,  6'd63},
    {6'd0,  6'd0,  6'd63, 6'd1},
    {6'd63, 6'd62, 6'd0,  6'd63},
    {6'd0,  6'd0,  6'd1,  6'd63},
    {6'd62, 6'd63, 6'd63, 6'd0},
    {6'd10, 6'd10, 6'd11, 6'd11},
    {6'd10, 6'd10, 6'd12, 6'd11},
    {6'd20, 6'd20, 6'd19, 6'd22},
    {6'd3,  6'd4,  6'd10, 6'd9},
    {6'd42, 6'd21, 6'd42, 6'd22},
    {6'd21, 6'd42, 6'd22, 6'd42}
  };

  // stimulus and verdict
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_segment(DIRECTED[i][23:18], DIRECTED[i][17:12], DIRECTED[i][11:6],
                   DIRECTED[i][5:0]);
    end

    // zero clip: every pixel outside
    run_phase(30, 24'h000000, 24'h000000, 24'h000000, 1'b0);
    // narrowest width, full height, long output hold
    run_phase(30, 24'hFFFFFF, 24'h000001, 24'h000040, 1'b1);
    // clip values above the tile, upper data bits set
    run_phase(30, CFG_W'($urandom), 24'hFFFFFF, 24'h123441, 1'b0);
    repeat (3) begin
      run_phase(25, CFG_W'($urandom), CFG_W'($urandom_range(1, 64)),
                CFG_W'($urandom_range(1, 64)), 1'b0);
    end
    // no idling on either side from here on
    wait_idle(SETTLE_CYCLES);
    calm_tail = 1'b1;
    run_phase(20, CFG_W'($urandom), 24'd64, 24'd64, 1'b0);

    wait_idle(DRAIN_CYCLES);
    $display("ran %0d segments, %0d pixels checked, %0d mismatches", segments_sent,
             pixels_seen, mismatch_cnt);
    $display("clip sizes 0, 1, 63-ish random, 64 and above tile; long output hold included");
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/lpr_pkg.sv
design/line_pixel_rasterizer.sv
dv/lpr_pixel_checker.sv
dv/testbench.sv
